>>> rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

    // counter width default, legal range 8 to 32
    localparam int COUNT_WIDTH = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DUR_W      = 16;
    localparam int CM_W       = 11;
    localparam int IN_W       = 9;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [7:0]       PRE_LOW_RST = 8'd5;
    localparam logic [7:0]       TRIGGER_RST = 8'd10;
    localparam logic [DUR_W-1:0] TIMEOUT_RST = 16'd50000;

    // 1/(2*29.1375) and 1/(2*74.00928) in q16, rounded
    localparam logic [CM_W-1:0] CM_Q16 = 11'd1125;
    localparam logic [IN_W-1:0] IN_Q16 = 9'd443;

    typedef struct packed {
        logic [7:0]       pre_low;
        logic [7:0]       trig_len;
        logic [DUR_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic             trig;
        logic             busy;
        logic             done;
        logic             tmo;
        logic [DUR_W-1:0] dur;
        logic [DUR_W-1:0] dist_dur;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/uer_dist.sv
`default_nettype none

// q16 scaling of the echo time into centimetres and inches
module uer_dist (
    input  wire logic [uer_pkg::DUR_W-1:0] i_dur,
    output logic      [uer_pkg::CM_W-1:0]  o_cm,
    output logic      [uer_pkg::IN_W-1:0]  o_in
);

    localparam int CM_PW = uer_pkg::DUR_W + uer_pkg::CM_W;
    localparam int IN_PW = uer_pkg::DUR_W + uer_pkg::IN_W;

    logic [CM_PW-1:0] cm_prod;
    logic [IN_PW-1:0] in_prod;

    assign cm_prod = CM_PW'(i_dur) * CM_PW'(uer_pkg::CM_Q16);
    assign in_prod = IN_PW'(i_dur) * IN_PW'(uer_pkg::IN_Q16);

    assign o_cm = cm_prod[CM_PW-1:16];
    assign o_in = in_prod[IN_PW-1:16];

endmodule

`default_nettype wire

>>> rtl/uer_ctrl.sv
`default_nettype none

// measurement sequencer, advanced by one tick per step
module uer_ctrl #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic          i_command,
    input  wire logic          i_echo_level,
    input  wire uer_pkg::t_cfg i_cfg,
    output uer_pkg::t_res      o_res
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_PRELOW = 5'b00010,
        PH_TRIG   = 5'b00100,
        PH_WAIT   = 5'b01000,
        PH_MEAS   = 5'b10000
    } t_phase;

    localparam logic [32:0] MAXC = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [COUNT_WIDTH-1:0] ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    t_phase                 r_phase, n_phase;
    logic [7:0]             r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0] r_el, n_el;

    logic [31:0]            cap_ext;
    logic [COUNT_WIDTH-1:0] cap;
    logic [7:0]             tlen;
    logic [7:0]             cnt_inc;
    logic [COUNT_WIDTH-1:0] el_inc;
    logic [31:0]            el_ext;
    t_phase                 ph;

    // timeout capped at the counter maximum
    assign cap_ext = (32'(i_cfg.timeout) > MAXC[31:0]) ? MAXC[31:0] : 32'(i_cfg.timeout);
    assign cap     = cap_ext[COUNT_WIDTH-1:0];
    assign tlen    = (i_cfg.trig_len != 8'd0) ? i_cfg.trig_len : 8'd1;
    assign cnt_inc = r_cnt + 8'd1;
    assign el_inc  = (r_el < cap) ? (r_el + ONE) : r_el;
    assign el_ext  = 32'(el_inc);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_el    = r_el;
        o_res   = '0;
        ph      = r_phase;
        if (r_phase == PH_IDLE && i_command) begin
            ph = (i_cfg.pre_low != 8'd0) ? PH_PRELOW : PH_TRIG;
        end
        unique case (ph)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_PRELOW: begin
                // a fresh start counts from zero
                if (r_phase == PH_IDLE || cnt_inc >= i_cfg.pre_low) begin
                    if (r_phase != PH_IDLE && cnt_inc >= i_cfg.pre_low) begin
                        n_phase = PH_TRIG;
                        n_cnt   = 8'd0;
                    end else if (8'd1 >= i_cfg.pre_low) begin
                        n_phase = PH_TRIG;
                        n_cnt   = 8'd0;
                    end else begin
                        n_phase = PH_PRELOW;
                        n_cnt   = 8'd1;
                    end
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_TRIG: begin
                o_res.trig = 1'b1;
                if (r_phase == PH_IDLE) begin
                    if (8'd1 >= tlen) begin
                        n_phase = PH_WAIT;
                        n_cnt   = 8'd0;
                        n_el    = '0;
                    end else begin
                        n_phase = PH_TRIG;
                        n_cnt   = 8'd1;
                    end
                end else if (cnt_inc >= tlen) begin
                    n_phase = PH_WAIT;
                    n_cnt   = 8'd0;
                    n_el    = '0;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_phase = PH_MEAS;
                    n_el    = '0;
                end else begin
                    n_el = el_inc;
                    if (el_inc >= cap) begin
                        o_res.done = 1'b1;
                        o_res.tmo  = 1'b1;
                        o_res.dur  = el_ext[uer_pkg::DUR_W-1:0];
                        n_phase    = PH_IDLE;
                    end
                end
            end
            PH_MEAS: begin
                n_el = el_inc;
                if (!i_echo_level) begin
                    o_res.done     = 1'b1;
                    o_res.dur      = el_ext[uer_pkg::DUR_W-1:0];
                    o_res.dist_dur = el_ext[uer_pkg::DUR_W-1:0];
                    n_phase        = PH_IDLE;
                end else if (el_inc >= cap) begin
                    o_res.done = 1'b1;
                    o_res.tmo  = 1'b1;
                    o_res.dur  = el_ext[uer_pkg::DUR_W-1:0];
                    n_phase    = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        o_res.busy = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 8'd0;
            r_el    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_el    <= n_el;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ultrasonic_echo_ranger.sv
// ultrasonic echo ranger
// input channel: one beat per microsecond tick, carrying the start command
//   and the sampled echo level; i_in_valid / o_in_stall, taken when valid
//   is high and stall is low
// output channel: exactly one result beat per input beat, in order, on
//   o_out_valid / i_out_stall: trigger level, busy, done, timeout flag,
//   duration in ticks and the distance in centimetres and inches
// path: a beat is registered on entry, then its tick is evaluated against the
//   sequencer state and the result is registered in the result register
// throughput: one beat per cycle while i_out_stall is low; the sequencer update is a few
//   compares, an increment, a 16 x 11 and a 16 x 9 multiply between entry and result registers
// stall: while the result register is held by i_out_stall the entry stage
//   holds too, and o_in_stall rises once the entry register is occupied
// reset: synchronous, active low; the sequencer returns to idle with its
//   counters cleared, both stages empty and the registers back to
//   pre-low 5, trigger 10, timeout 50000
// configuration: plain write port; the user writes only while no tick is in flight, unchecked
`default_nettype none

module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // tick channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_command,
    input  wire logic                            i_echo_level,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_trigger_out,
    output logic                                 o_busy_res,
    output logic                                 o_done_res,
    output logic                                 o_timed_out,
    output logic [uer_pkg::DUR_W-1:0]            o_duration_ticks,
    output logic [uer_pkg::CM_W-1:0]             o_distance_cm,
    output logic [uer_pkg::IN_W-1:0]             o_distance_in
);

    uer_pkg::t_cfg r_cfg;

    // entry stage
    logic r_in_valid;
    logic r_command;
    logic r_echo;

    // result stage
    logic                       r_out_valid;
    uer_pkg::t_res              r_res;
    logic [uer_pkg::CM_W-1:0]   r_cm;
    logic [uer_pkg::IN_W-1:0]   r_in;

    logic                       in_take;
    logic                       step;
    uer_pkg::t_res              res;
    logic [uer_pkg::CM_W-1:0]   cm;
    logic [uer_pkg::IN_W-1:0]   inch;

    // the entry beat moves on when the result register is free or being drained
    assign step       = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_low  <= uer_pkg::PRE_LOW_RST;
            r_cfg.trig_len <= uer_pkg::TRIGGER_RST;
            r_cfg.timeout  <= uer_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                uer_pkg::REG_PRE_LOW: r_cfg.pre_low  <= i_cfg_data[7:0];
                uer_pkg::REG_TRIGGER: r_cfg.trig_len <= i_cfg_data[7:0];
                uer_pkg::REG_TIMEOUT: r_cfg.timeout  <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command <= i_command;
            r_echo    <= i_echo_level;
        end
    end

    uer_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_command    (r_command),
        .i_echo_level (r_echo),
        .i_cfg        (r_cfg),
        .o_res        (res)
    );

    // distances only for a normal finish, zero otherwise
    uer_dist u_dist (
        .i_dur (res.dist_dur),
        .o_cm  (cm),
        .o_in  (inch)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
            r_cm  <= cm;
            r_in  <= inch;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_trigger_out    = r_res.trig;
    assign o_busy_res       = r_res.busy;
    assign o_done_res       = r_res.done;
    assign o_timed_out      = r_res.tmo;
    assign o_duration_ticks = r_res.dur;
    assign o_distance_cm    = r_cm;
    assign o_distance_in    = r_in;

endmodule

`default_nettype wire

>>> rtl/uer_checker.sv
`default_nettype none

module uer_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_we,
    input wire logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input wire logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            i_command,
    input wire logic                            i_echo_level,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic                            o_trigger_out,
    input wire logic                            o_busy_res,
    input wire logic                            o_done_res,
    input wire logic                            o_timed_out,
    input wire logic [uer_pkg::DUR_W-1:0]       o_duration_ticks,
    input wire logic [uer_pkg::CM_W-1:0]        o_distance_cm,
    input wire logic [uer_pkg::IN_W-1:0]        o_distance_in
);

    // a beat that finishes nothing carries no measurement
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |->
            (o_duration_ticks == '0 && o_distance_cm == '0 && o_distance_in == '0
             && !o_timed_out))
        else $error("measurement fields set on a beat that finishes nothing");

    // a timeout reports no distance
    a_tmo_nodist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timed_out) |->
            (o_done_res && o_distance_cm == '0 && o_distance_in == '0))
        else $error("timeout beat with distance");

    // the finishing beat leaves the sequencer idle, trigger only mid-measurement
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_done_res || o_trigger_out)) |->
            ((o_done_res && !o_busy_res && !o_trigger_out)
             || (o_trigger_out && o_busy_res && !o_done_res)))
        else $error("busy flag disagrees with done or trigger");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_duration_ticks) && $stable(o_done_res)))
        else $error("stalled result beat changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire

>>> sim/tb_ultrasonic_echo_ranger.sv
`default_nettype none

module tb_ultrasonic_echo_ranger;
    timeunit 1ns;
    timeprecision 1ps;

    // index 3 is not decoded, a write there must change nothing
    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // q16 factors for ticks to centimetres and ticks to inches
    localparam int unsigned CM_PER_TICK_Q16 = 1125;
    localparam int unsigned IN_PER_TICK_Q16 = 443;

    localparam int N_DIR     = 24;
    localparam int N_RANDOM  = 1150;
    localparam int MAX_SHOWN = 10;

    // sequencer phases of the ranging model
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PRELOW,
        SEQ_TRIG,
        SEQ_WAIT,
        SEQ_MEAS
    } t_seq;

    // one result beat as the block presents it
    typedef struct packed {
        logic                     trig;
        logic                     busy;
        logic                     done;
        logic                     tmo;
        logic [uer_pkg::DUR_W-1:0] dur;
        logic [uer_pkg::CM_W-1:0]  cm;
        logic [uer_pkg::IN_W-1:0]  inch;
    } t_tick_res;

    typedef enum bit {ROW_TICK, ROW_CFG} t_row_kind;

    // one row of the directed table: a tick beat or a register write
    typedef struct {
        t_row_kind                      kind;
        bit                             cmd;
        bit                             echo;
        logic [uer_pkg::CFG_IDX_W-1:0]  idx;
        logic [uer_pkg::CFG_DATA_W-1:0] data;
        bit                             typed;
        t_tick_res                      res;
    } t_row;

    // inputs of the block, all at known levels from time zero
    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_cfg_we     = 1'b0;
    logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_stall;
    logic                           i_command    = 1'b0;
    logic                           i_echo_level = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall  = 1'b0;
    logic                           o_trigger_out;
    logic                           o_busy_res;
    logic                           o_done_res;
    logic                           o_timed_out;
    logic [uer_pkg::DUR_W-1:0]      o_duration_ticks;
    logic [uer_pkg::CM_W-1:0]       o_distance_cm;
    logic [uer_pkg::IN_W-1:0]       o_distance_in;

    // ranging model state and its copy of the registers
    logic [7:0]                sq_pre_low  = uer_pkg::PRE_LOW_RST;
    logic [7:0]                sq_trig_len = uer_pkg::TRIGGER_RST;
    logic [uer_pkg::DUR_W-1:0] sq_timeout  = uer_pkg::TIMEOUT_RST;
    t_seq                      sq_phase    = SEQ_IDLE;
    logic [7:0]                sq_count    = 8'd0;
    logic [uer_pkg::DUR_W-1:0] sq_elapsed  = '0;

    // results still owed by the block, oldest first
    t_tick_res tick_res_q[$];

    int n_err     = 0;
    int n_ticks   = 0;
    int n_results = 0;
    // while set: no gap before a tick, no new random stall (hold-offs still apply)
    bit calm      = 1'b0;

    t_row dir_rows [N_DIR];

    ultrasonic_echo_ranger #(
        .COUNT_WIDTH (uer_pkg::COUNT_WIDTH)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_echo_level     (i_echo_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_trigger_out    (o_trigger_out),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_timed_out      (o_timed_out),
        .o_duration_ticks (o_duration_ticks),
        .o_distance_cm    (o_distance_cm),
        .o_distance_in    (o_distance_in)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void note_error(string msg);
        n_err++;
        if (n_err <= MAX_SHOWN) $display("error: %s", msg);
    endfunction

    // flags in order: trigger, busy, done, timeout
    function automatic t_tick_res mk_res(bit [3:0] flags, logic [uer_pkg::DUR_W-1:0] dur);
        t_tick_res r;
        // every typed row has a duration too short for a nonzero distance
        r      = '0;
        r.trig = flags[3];
        r.busy = flags[2];
        r.done = flags[1];
        r.tmo  = flags[0];
        r.dur  = dur;
        return r;
    endfunction

    // advance the ranging model by one tick and return what the block must show
    function automatic t_tick_res range_tick(bit cmd, bit echo);
        t_tick_res   r;
        logic [7:0]  trig_len;
        logic [31:0] prod_cm;
        logic [31:0] prod_in;
        r = '0;
        // a zero trigger length still gives one high tick
        trig_len = (sq_trig_len == 8'd0) ? 8'd1 : sq_trig_len;
        // starts count only from idle, so also not on the finishing tick
        if (sq_phase == SEQ_IDLE && cmd) begin
            sq_phase = (sq_pre_low != 8'd0) ? SEQ_PRELOW : SEQ_TRIG;
            sq_count = 8'd0;
        end
        // with a 16-bit counter the saturation cap is the timeout itself
        case (sq_phase)
            SEQ_PRELOW: begin
                sq_count = sq_count + 8'd1;
                if (sq_count >= sq_pre_low) begin
                    sq_phase = SEQ_TRIG;
                    sq_count = 8'd0;
                end
            end
            SEQ_TRIG: begin
                r.trig   = 1'b1;
                sq_count = sq_count + 8'd1;
                if (sq_count >= trig_len) begin
                    sq_phase   = SEQ_WAIT;
                    sq_count   = 8'd0;
                    sq_elapsed = '0;
                end
            end
            SEQ_WAIT: begin
                // a level already high counts as the rising edge
                if (echo) begin
                    sq_phase   = SEQ_MEAS;
                    sq_elapsed = '0;
                end else begin
                    if (sq_elapsed < sq_timeout) sq_elapsed = sq_elapsed + 1'b1;
                    if (sq_elapsed >= sq_timeout) begin
                        r.done   = 1'b1;
                        r.tmo    = 1'b1;
                        r.dur    = sq_elapsed;
                        sq_phase = SEQ_IDLE;
                    end
                end
            end
            SEQ_MEAS: begin
                if (sq_elapsed < sq_timeout) sq_elapsed = sq_elapsed + 1'b1;
                if (!echo) begin
                    prod_cm  = 32'(sq_elapsed) * CM_PER_TICK_Q16;
                    prod_in  = 32'(sq_elapsed) * IN_PER_TICK_Q16;
                    r.done   = 1'b1;
                    r.dur    = sq_elapsed;
                    r.cm     = uer_pkg::CM_W'(prod_cm >> 16);
                    r.inch   = uer_pkg::IN_W'(prod_in >> 16);
                    sq_phase = SEQ_IDLE;
                end else if (sq_elapsed >= sq_timeout) begin
                    r.done   = 1'b1;
                    r.tmo    = 1'b1;
                    r.dur    = sq_elapsed;
                    sq_phase = SEQ_IDLE;
                end
            end
            default: begin
                sq_phase = SEQ_IDLE;
            end
        endcase
        r.busy = (sq_phase != SEQ_IDLE);
        return r;
    endfunction

    // offer one tick beat after a random gap; returns at the edge that took it
    task automatic send_tick(input bit cmd, input bit echo,
                             input bit typed = 1'b0, input t_tick_res typed_res = '0);
        int        gap;
        int        pick;
        t_tick_res res;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60) gap = 0;
        else if (pick < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(5, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = range_tick(cmd, echo);
        tick_res_q.push_back(typed ? typed_res : res);
        n_ticks++;
    endtask

    // steer the echo so that a running measurement ends quickly
    task automatic finish_measurement();
        while (sq_phase != SEQ_IDLE) send_tick(1'b0, sq_phase == SEQ_WAIT);
    endtask

    // register write, only once every owed result is out and the pipe is empty
    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_W-1:0] value);
        logic [uer_pkg::CFG_DATA_W-1:0] word;
        word = value;
        // the 8-bit registers must drop the upper half of the word
        if (idx != uer_pkg::REG_TIMEOUT) word[15:8] = 8'($urandom);
        i_in_valid <= 1'b0;
        while (tick_res_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            uer_pkg::REG_PRE_LOW: sq_pre_low  = word[7:0];
            uer_pkg::REG_TRIGGER: sq_trig_len = word[7:0];
            uer_pkg::REG_TIMEOUT: sq_timeout  = word;
            default: ;
        endcase
    endtask

    // one well-formed measurement: start, w low ticks, h high ticks, then low
    task automatic range_once(input int w, input int h);
        send_tick(1'b1, 1'($urandom));
        // pre-low and trigger: echo is noise and stray starts are ignored
        while (sq_phase == SEQ_PRELOW || sq_phase == SEQ_TRIG)
            send_tick($urandom_range(0, 7) == 0, 1'($urandom));
        repeat (w) send_tick($urandom_range(0, 15) == 0, 1'b0);
        repeat (h) send_tick($urandom_range(0, 15) == 0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // result side: checks every beat taken and makes its own stall pattern
    initial begin : result_side
        t_tick_res got;
        t_tick_res want;
        int        stall_left;
        int        hold_left;
        int        next_hold_at;
        int        pick;
        stall_left   = 0;
        hold_left    = 0;
        next_hold_at = 300;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.trig = o_trigger_out;
                got.busy = o_busy_res;
                got.done = o_done_res;
                got.tmo  = o_timed_out;
                got.dur  = o_duration_ticks;
                got.cm   = o_distance_cm;
                got.inch = o_distance_in;
                n_results++;
                if (tick_res_q.size() == 0) begin
                    note_error($sformatf("result beat %0d with nothing expected", n_results));
                end else begin
                    want = tick_res_q.pop_front();
                    if (got !== want) begin
                        note_error($sformatf({"result beat %0d: expected trig %0b busy %0b ",
                            "done %0b tmo %0b dur %0d cm %0d in %0d, got trig %0b busy %0b ",
                            "done %0b tmo %0b dur %0d cm %0d in %0d"}, n_results,
                            want.trig, want.busy, want.done, want.tmo, want.dur, want.cm,
                            want.inch, got.trig, got.busy, got.done, got.tmo, got.dur,
                            got.cm, got.inch));
                    end
                end
            end
            // now and then a long hold-off so the block fills and stalls its input
            if (hold_left == 0 && n_results >= next_hold_at && next_hold_at < 2000) begin
                hold_left    = 250;
                next_hold_at = next_hold_at + 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    i_out_stall <= 1'b0;
                end else begin
                    // mostly short stalls, a few long ones
                    stall_left  = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    // stimulus side
    initial begin : tick_side
        int                        w;
        int                        h;
        int                        n_meas;
        int                        phase_no;
        int                        settle;
        logic [7:0]                pre;
        logic [7:0]                trg;
        logic [uer_pkg::DUR_W-1:0] tmo;

        // directed table; rows with a typed result are checked against it,
        // the others against the ranging model
        dir_rows = '{
            // after reset: idle ticks show nothing, whatever the echo
            '{ROW_TICK, 1'b0, 1'b1, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0000, 16'd0)},
            '{ROW_TICK, 1'b0, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0000, 16'd0)},
            // start with reset settings: first pre-low tick, trigger still low
            '{ROW_TICK, 1'b1, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0100, 16'd0)},
            // no pre-low, zero trigger length, timeout of 3
            '{ROW_CFG,  1'b0, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_CFG,  1'b0, 1'b0, uer_pkg::REG_TRIGGER, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_CFG,  1'b0, 1'b0, uer_pkg::REG_TIMEOUT, 16'd3, 1'b0, mk_res(4'b0000, 16'd0)},
            // start tick is already the trigger tick
            '{ROW_TICK, 1'b1, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b1100, 16'd0)},
            // start while busy is ignored
            '{ROW_TICK, 1'b1, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_TICK, 1'b0, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            // no echo edge: timeout on the tick the count reaches 3
            '{ROW_TICK, 1'b0, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0011, 16'd3)},
            '{ROW_TICK, 1'b1, 1'b1, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b1100, 16'd0)},
            // echo already high when the wait begins
            '{ROW_TICK, 1'b0, 1'b1, uer_pkg::REG_PRE_LOW, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_TICK, 1'b0, 1'b1, uer_pkg::REG_PRE_LOW, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            // falling edge after two ticks, start on the finishing tick ignored
            '{ROW_TICK, 1'b1, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0010, 16'd2)},
            // zero timeout ends either wait at once
            '{ROW_CFG,  1'b0, 1'b0, uer_pkg::REG_TIMEOUT, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_TICK, 1'b1, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b1100, 16'd0)},
            '{ROW_TICK, 1'b0, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0011, 16'd0)},
            '{ROW_TICK, 1'b1, 1'b1, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b1100, 16'd0)},
            '{ROW_TICK, 1'b0, 1'b1, uer_pkg::REG_PRE_LOW, 16'd0, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_TICK, 1'b0, 1'b1, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0011, 16'd0)},
            // largest settings
            '{ROW_CFG,  1'b0, 1'b0, uer_pkg::REG_PRE_LOW, 16'd255, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_CFG,  1'b0, 1'b0, uer_pkg::REG_TRIGGER, 16'd255, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_CFG,  1'b0, 1'b0, uer_pkg::REG_TIMEOUT, 16'hFFFF, 1'b0, mk_res(4'b0000, 16'd0)},
            '{ROW_TICK, 1'b1, 1'b0, uer_pkg::REG_PRE_LOW, 16'd0, 1'b1, mk_res(4'b0100, 16'd0)}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                finish_measurement();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_tick(dir_rows[k].cmd, dir_rows[k].echo, dir_rows[k].typed,
                          dir_rows[k].res);
            end
        end

        // random phases, each with its own register settings
        phase_no = 0;
        while (phase_no < 4 || n_ticks < N_DIR + N_RANDOM) begin
            case (phase_no)
                0: begin
                    pre = uer_pkg::PRE_LOW_RST;
                    trg = uer_pkg::TRIGGER_RST;
                    tmo = uer_pkg::TIMEOUT_RST;
                end
                1: begin
                    pre = 8'd0;
                    trg = 8'd1;
                    tmo = 16'd1;
                end
                2: begin
                    // longest timeout behind a short trigger sequence
                    pre = 8'd2;
                    trg = 8'd3;
                    tmo = 16'hFFFF;
                end
                3: begin
                    pre = 8'd1;
                    trg = 8'd0;
                    tmo = 16'd0;
                end
                default: begin
                    pre = 8'($urandom_range(0, 8));
                    trg = 8'($urandom_range(0, 8));
                    w   = $urandom_range(0, 99);
                    if (w < 50) tmo = 16'($urandom_range(1, 30));
                    else if (w < 80) tmo = 16'($urandom_range(31, 700));
                    else if (w < 85) tmo = 16'd0;
                    else tmo = 16'($urandom);
                end
            endcase
            finish_measurement();
            write_reg(uer_pkg::REG_PRE_LOW, {8'd0, pre});
            write_reg(uer_pkg::REG_TRIGGER, {8'd0, trg});
            write_reg(uer_pkg::REG_TIMEOUT, tmo);
            write_reg(REG_UNUSED, 16'($urandom));
            calm   = (phase_no % 4 == 3);
            n_meas = $urandom_range(1, 2);
            repeat (n_meas) begin
                // wait for the edge: mostly short, sometimes up to and past the timeout
                if ($urandom_range(0, 9) < 7) w = $urandom_range(0, 20);
                else w = $urandom_range(0, (tmo > 16'd78) ? 80 : int'(tmo) + 2);
                h = $urandom_range(0, 99);
                if (h < 60) h = $urandom_range(0, 40);
                else if (h < 85) h = $urandom_range(41, 120);
                else h = $urandom_range(121, 700);
                range_once(w, h);
                // noise between measurements
                repeat ($urandom_range(0, 4)) send_tick($urandom_range(0, 5) == 0, 1'($urandom));
            end
            phase_no++;
        end

        // one echo that outlasts the timeout, so the counter saturates while high
        finish_measurement();
        write_reg(uer_pkg::REG_PRE_LOW, 16'd1);
        write_reg(uer_pkg::REG_TRIGGER, 16'd1);
        write_reg(uer_pkg::REG_TIMEOUT, 16'd40);
        calm = 1'b1;
        range_once(3, 60);
        calm = 1'b0;

        // drain the owed results, then let the pipe settle
        i_in_valid <= 1'b0;
        settle = 0;
        while (tick_res_q.size() != 0 && settle < 20000) begin
            @(posedge i_clk);
            settle++;
        end
        if (tick_res_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived", tick_res_q.size()));
        repeat (10) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb_ultrasonic_echo_ranger OK");
        end else begin
            $display("tb_ultrasonic_echo_ranger NOT OK");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #20ms;
        $display("tb_ultrasonic_echo_ranger NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/uer_pkg.sv
rtl/uer_dist.sv
rtl/uer_ctrl.sv
rtl/ultrasonic_echo_ranger.sv
rtl/uer_checker.sv
sim/tb_ultrasonic_echo_ranger.sv
